### rtl/vector_jacobian_derived_measures_assert.svh
// assertion macros for the vector/jacobian measures block
// no dependencies; included by the top level only
`ifndef VECTOR_JACOBIAN_DERIVED_MEASURES_ASSERT_SVH
`define VECTOR_JACOBIAN_DERIVED_MEASURES_ASSERT_SVH

`ifndef ASSERT_OFF
`define VJDM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define VJDM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define VJDM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define VJDM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

### rtl/vjdm_pkg.sv
// shared constants and types for the vector/jacobian measures block
// no dependencies
package vjdm_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int MASK_W         = 6;
    localparam logic [MASK_W-1:0] MASK_RESET = 6'd63;

    localparam int BIT_LEN  = 1;
    localparam int BIT_NORM = 2;
    localparam int BIT_DIV  = 4;
    localparam int BIT_CURL = 5;

    localparam int LEN_W   = 16;
    localparam int NORM_W  = 16;
    localparam int DIV_W   = 18;
    localparam int CURL_W  = 17;

    // normal magnitude lies in 0..16384, so 15 result bits
    localparam int NORM_BITS  = 15;
    // 4 * c^2 * 2^28 on the right-hand side of the rounding test
    localparam int NORM_SHIFT = 30;

    typedef struct packed {
        logic                     len_en;
        logic                     norm_en;
        logic [2:0]               neg;
        logic signed [DIV_W-1:0]  div;
        logic signed [CURL_W-1:0] curl_x;
        logic signed [CURL_W-1:0] curl_y;
        logic signed [CURL_W-1:0] curl_z;
    } vjdm_side_t;

endpackage

### rtl/vjdm_front.sv
// front stages: magnitudes, squares and sum of squares; divergence and curl
// depends on vjdm_pkg
module vjdm_front #(
    parameter int W = vjdm_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [vjdm_pkg::MASK_W-1:0] mask,
    input  logic signed [W-1:0]         vec [3],
    input  logic signed [W-1:0]         jac [9],
    output logic                        out_valid,
    output logic [2*W-1:0]              sum_sq,
    output logic [2*W-1:0]              sq [3],
    output vjdm_pkg::vjdm_side_t        side
);
    import vjdm_pkg::*;

    logic signed [63:0] jx [9];
    logic [W-1:0]       abs_next [3];
    vjdm_side_t         side1_next;

    logic [2:0]   valid_reg;
    logic [W-1:0] abs_reg [3];
    vjdm_side_t   side1_reg, side2_reg, side3_reg;
    logic [2*W-1:0] sq2_reg [3];
    logic [2*W-1:0] sq3_reg [3];
    logic [2*W-1:0] sum_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            jx[i] = 64'(jac[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            abs_next[i] = vec[i][W-1] ? (~vec[i] + W'(1)) : vec[i];
        end
        side1_next.len_en  = mask[BIT_LEN];
        side1_next.norm_en = mask[BIT_NORM];
        side1_next.neg     = {vec[2][W-1], vec[1][W-1], vec[0][W-1]};
        // sums wrap, so working on the low bits alone is exact
        side1_next.div     = mask[BIT_DIV]
                           ? jx[0][DIV_W-1:0] + jx[4][DIV_W-1:0] + jx[8][DIV_W-1:0]
                           : '0;
        side1_next.curl_x  = mask[BIT_CURL] ? jx[5][CURL_W-1:0] - jx[7][CURL_W-1:0] : '0;
        side1_next.curl_y  = mask[BIT_CURL] ? jx[6][CURL_W-1:0] - jx[2][CURL_W-1:0] : '0;
        side1_next.curl_z  = mask[BIT_CURL] ? jx[1][CURL_W-1:0] - jx[3][CURL_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_reg[i] <= abs_next[i];
            sq2_reg[i] <= (2*W)'(abs_reg[i]) * (2*W)'(abs_reg[i]);
            sq3_reg[i] <= sq2_reg[i];
        end
        side1_reg <= side1_next;
        side2_reg <= side1_reg;
        side3_reg <= side2_reg;
        sum_reg   <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
    end

    assign out_valid = valid_reg[2];
    assign sum_sq    = sum_reg;
    assign sq        = sq3_reg;
    assign side      = side3_reg;

endmodule

### rtl/vjdm_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on vjdm_pkg only for the default width
module vjdm_isqrt #(
    parameter int W      = vjdm_pkg::DATA_WIDTH_DEF,
    parameter int STAGES = vjdm_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic [2*W-1:0] sum_sq,
    output logic [W-1:0]   root
);
    localparam int TW = 2*W + 1;

    logic [W-1:0]   r_reg  [1:STAGES];
    logic [2*W-1:0] r2_reg [1:STAGES];
    logic [2*W-1:0] s_reg  [1:STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [W-1:0]   r_cur;
        logic [2*W-1:0] r2_cur;
        logic [2*W-1:0] s_cur;

        if (k == 0)
        begin : g_first
            assign r_cur  = '0;
            assign r2_cur = '0;
            assign s_cur  = sum_sq;
        end
        else
        begin : g_mid
            assign r_cur  = r_reg[k];
            assign r2_cur = r2_reg[k];
            assign s_cur  = s_reg[k];
        end

        if (W - 1 - k >= 0)
        begin : g_bit
            localparam int B = W - 1 - k;
            logic [TW-1:0] trial;
            // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
            assign trial = TW'(r2_cur) + (TW'(r_cur) << (B + 1)) + (TW'(1) << (2 * B));

            always_ff @(posedge clk)
            begin
                s_reg[k+1] <= s_cur;
                if (trial <= TW'(s_cur))
                begin
                    r_reg[k+1]  <= r_cur | (W'(1) << B);
                    r2_reg[k+1] <= trial[2*W-1:0];
                end
                else
                begin
                    r_reg[k+1]  <= r_cur;
                    r2_reg[k+1] <= r2_cur;
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                s_reg[k+1]  <= s_cur;
                r_reg[k+1]  <= r_cur;
                r2_reg[k+1] <= r2_cur;
            end
        end
    end

    assign root = r_reg[STAGES];

endmodule

### rtl/vjdm_norm.sv
// pipelined rounded normal magnitude |c| * 2^14 / sqrt(s), one bit per stage
// depends on vjdm_pkg
module vjdm_norm #(
    parameter int W      = vjdm_pkg::DATA_WIDTH_DEF,
    parameter int STAGES = vjdm_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic [2*W-1:0]                 sum_sq,
    input  logic [2*W-1:0]                 comp_sq,
    output logic [vjdm_pkg::NORM_BITS-1:0] mag
);
    import vjdm_pkg::*;

    // p tracks (2m-1)^2 * s, q tracks (2m-1) * s, so each trial is adds only
    localparam int PW = 2*W + 34;
    localparam int QW = 2*W + 18;

    logic signed [PW-1:0]  p_reg   [1:STAGES];
    logic signed [QW-1:0]  q_reg   [1:STAGES];
    logic signed [PW-1:0]  rhs_reg [1:STAGES];
    logic [2*W-1:0]        s_reg   [1:STAGES];
    logic [NORM_BITS-1:0]  m_reg   [1:STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic signed [PW-1:0] p_cur;
        logic signed [QW-1:0] q_cur;
        logic signed [PW-1:0] rhs_cur;
        logic [2*W-1:0]       s_cur;
        logic [NORM_BITS-1:0] m_cur;

        if (k == 0)
        begin : g_first
            logic signed [PW-1:0] s_p;
            logic signed [QW-1:0] s_q;
            logic signed [PW-1:0] c_p;
            assign s_p     = PW'(sum_sq);
            assign s_q     = QW'(sum_sq);
            assign c_p     = PW'(comp_sq);
            assign p_cur   = s_p;
            assign q_cur   = -s_q;
            assign rhs_cur = c_p <<< NORM_SHIFT;
            assign s_cur   = sum_sq;
            assign m_cur   = '0;
        end
        else
        begin : g_mid
            assign p_cur   = p_reg[k];
            assign q_cur   = q_reg[k];
            assign rhs_cur = rhs_reg[k];
            assign s_cur   = s_reg[k];
            assign m_cur   = m_reg[k];
        end

        if (NORM_BITS - 1 - k >= 0)
        begin : g_bit
            localparam int B = NORM_BITS - 1 - k;
            logic signed [PW-1:0] q_ext;
            logic signed [PW-1:0] s_pw;
            logic signed [QW-1:0] s_qw;
            logic signed [PW-1:0] trial;
            assign q_ext = PW'(q_cur);
            assign s_pw  = PW'(s_cur);
            assign s_qw  = QW'(s_cur);
            assign trial = p_cur + (q_ext <<< (B + 2)) + (s_pw <<< (2 * B + 2));

            always_ff @(posedge clk)
            begin
                s_reg[k+1]   <= s_cur;
                rhs_reg[k+1] <= rhs_cur;
                if (trial <= rhs_cur)
                begin
                    p_reg[k+1] <= trial;
                    q_reg[k+1] <= q_cur + (s_qw <<< (B + 1));
                    m_reg[k+1] <= m_cur | (NORM_BITS'(1) << B);
                end
                else
                begin
                    p_reg[k+1] <= p_cur;
                    q_reg[k+1] <= q_cur;
                    m_reg[k+1] <= m_cur;
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                s_reg[k+1]   <= s_cur;
                rhs_reg[k+1] <= rhs_cur;
                p_reg[k+1]   <= p_cur;
                q_reg[k+1]   <= q_cur;
                m_reg[k+1]   <= m_cur;
            end
        end
    end

    assign mag = m_reg[STAGES];

endmodule

### rtl/vector_jacobian_derived_measures.sv
// Derived measures of a probed vector sample and its 3x3 Jacobian.
// Requests enter on start with vec_x..vec_z and jac_0..jac_8 (signed Q4.11);
// busy is always low, so a request is taken in every cycle that start is high.
// Each request gives one result, shown for one cycle with done high:
// vec_length, norm_x/y/z (Q1.14), divergence and curl_x/y/z. Measures not
// selected in query_mask read zero; a zero vector gives a zero normal.
// A request passes through three front stages, the square-root and normal
// units, which resolve one bit per stage, and one output register.
// Throughput is one request per cycle.
// query_mask is written on the cfg channel (cfg_ready always high) and
// resets to 63. The user must write it only while no request is in
// flight; the block itself does not enforce this.
// Reset clears the pipeline valid bits and sets the mask back to 63; any
// request in flight is dropped. Results cannot be held off and the pipeline
// never stalls.
// Depends on vjdm_pkg, vjdm_front, vjdm_isqrt, vjdm_norm and the assert header.
`include "vector_jacobian_derived_measures_assert.svh"

module vector_jacobian_derived_measures #(
    parameter int DATA_WIDTH = vjdm_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [DATA_WIDTH-1:0]       vec_x,
    input  logic signed [DATA_WIDTH-1:0]       vec_y,
    input  logic signed [DATA_WIDTH-1:0]       vec_z,
    input  logic signed [DATA_WIDTH-1:0]       jac_0,
    input  logic signed [DATA_WIDTH-1:0]       jac_1,
    input  logic signed [DATA_WIDTH-1:0]       jac_2,
    input  logic signed [DATA_WIDTH-1:0]       jac_3,
    input  logic signed [DATA_WIDTH-1:0]       jac_4,
    input  logic signed [DATA_WIDTH-1:0]       jac_5,
    input  logic signed [DATA_WIDTH-1:0]       jac_6,
    input  logic signed [DATA_WIDTH-1:0]       jac_7,
    input  logic signed [DATA_WIDTH-1:0]       jac_8,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vjdm_pkg::MASK_W-1:0]        cfg_data,
    output logic                               done,
    output logic [vjdm_pkg::LEN_W-1:0]         vec_length,
    output logic signed [vjdm_pkg::NORM_W-1:0] norm_x,
    output logic signed [vjdm_pkg::NORM_W-1:0] norm_y,
    output logic signed [vjdm_pkg::NORM_W-1:0] norm_z,
    output logic signed [vjdm_pkg::DIV_W-1:0]  divergence,
    output logic signed [vjdm_pkg::CURL_W-1:0] curl_x,
    output logic signed [vjdm_pkg::CURL_W-1:0] curl_y,
    output logic signed [vjdm_pkg::CURL_W-1:0] curl_z
);
    import vjdm_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int DEPTH = (W > NORM_BITS) ? W : NORM_BITS;
    localparam int LAT   = DEPTH + 4;

    logic [MASK_W-1:0] query_mask_reg;

    logic signed [W-1:0] vec [3];
    logic signed [W-1:0] jac [9];

    logic           front_valid;
    logic [2*W-1:0] sum_sq;
    logic [2*W-1:0] sq [3];
    vjdm_side_t     front_side;

    logic [W-1:0]         root;
    logic [NORM_BITS-1:0] mag [3];

    logic [DEPTH-1:0] valid_reg;
    vjdm_side_t       side_reg [1:DEPTH];
    vjdm_side_t       side_end;

    logic signed [NORM_W-1:0] norm_next [3];

    logic                     done_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [NORM_W-1:0] norm_reg [3];
    logic signed [DIV_W-1:0]  div_reg;
    logic signed [CURL_W-1:0] cx_reg, cy_reg, cz_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_mask_reg <= MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            query_mask_reg <= cfg_data;
        end
    end

    assign vec = '{vec_x, vec_y, vec_z};
    assign jac = '{jac_0, jac_1, jac_2, jac_3, jac_4, jac_5, jac_6, jac_7, jac_8};

    vjdm_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .mask      (query_mask_reg),
        .vec       (vec),
        .jac       (jac),
        .out_valid (front_valid),
        .sum_sq    (sum_sq),
        .sq        (sq),
        .side      (front_side)
    );

    vjdm_isqrt #(.W(W), .STAGES(DEPTH)) u_isqrt (
        .clk    (clk),
        .sum_sq (sum_sq),
        .root   (root)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_norm
        vjdm_norm #(.W(W), .STAGES(DEPTH)) u_norm (
            .clk     (clk),
            .sum_sq  (sum_sq),
            .comp_sq (sq[i]),
            .mag     (mag[i])
        );
    end

    // side data and valid bits keep step with the bit-serial units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], front_valid};
            done_reg  <= valid_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[1] <= front_side;
        for (int k = 2; k <= DEPTH; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign side_end = side_reg[DEPTH];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (side_end.norm_en && (root != '0))
            begin
                norm_next[i] = side_end.neg[i] ? -NORM_W'(mag[i]) : NORM_W'(mag[i]);
            end
            else
            begin
                norm_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= side_end.len_en ? LEN_W'(root) : '0;
        norm_reg <= norm_next;
        div_reg  <= side_end.div;
        cx_reg   <= side_end.curl_x;
        cy_reg   <= side_end.curl_y;
        cz_reg   <= side_end.curl_z;
    end

    assign done       = done_reg;
    assign vec_length = len_reg;
    assign norm_x     = norm_reg[0];
    assign norm_y     = norm_reg[1];
    assign norm_z     = norm_reg[2];
    assign divergence = div_reg;
    assign curl_x     = cx_reg;
    assign curl_y     = cy_reg;
    assign curl_z     = cz_reg;

    `VJDM_ASSERT_IMPLY(a_done_follows_request, clk, rst_n, done, $past(start && !busy, LAT))
    `VJDM_ASSERT_IMPLY(a_len_masked, clk, rst_n, done && !query_mask_reg[BIT_LEN], vec_length == '0)
    `VJDM_ASSERT_IMPLY(a_norm_range, clk, rst_n, done, (norm_x <= 16384) && (norm_x >= -16384))
    `VJDM_ASSERT_NEXT(a_no_request_no_done, clk, rst_n, !front_valid && (valid_reg == '0), !done)

endmodule
